// ----- rtl/fcb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the 80-bit-key Feistel block cipher unit: types, constants,
// the substitution table and the G and whitening functions. No dependencies.
package fcb_pkg;

  localparam int unsigned ROUNDS   = 20;
  localparam int unsigned ROUND_AW = 5;
  localparam int unsigned SK_W     = 96;
  localparam int unsigned KEY_W    = 80;
  localparam int unsigned BLK_W    = 64;
  localparam logic [ROUND_AW-1:0] LAST_ROUND = ROUND_AW'(ROUNDS - 1);

  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;

  typedef enum logic {
    ST_IDLE,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic                en;
    logic [ROUND_AW-1:0] addr;
    logic [SK_W-1:0]     data;
  } kwr_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'ha3, 8'hd7, 8'h09, 8'h83, 8'hf8, 8'h48, 8'hf6, 8'hf4, 8'hb3, 8'h21, 8'h15, 8'h78,
    8'h99, 8'hb1, 8'haf, 8'hf9, 8'he7, 8'h2d, 8'h4d, 8'h8a, 8'hce, 8'h4c, 8'hca, 8'h2e,
    8'h52, 8'h95, 8'hd9, 8'h1e, 8'h4e, 8'h38, 8'h44, 8'h28, 8'h0a, 8'hdf, 8'h02, 8'ha0,
    8'h17, 8'hf1, 8'h60, 8'h68, 8'h12, 8'hb7, 8'h7a, 8'hc3, 8'he9, 8'hfa, 8'h3d, 8'h53,
    8'h96, 8'h84, 8'h6b, 8'hba, 8'hf2, 8'h63, 8'h9a, 8'h19, 8'h7c, 8'hae, 8'he5, 8'hf5,
    8'hf7, 8'h16, 8'h6a, 8'ha2, 8'h39, 8'hb6, 8'h7b, 8'h0f, 8'hc1, 8'h93, 8'h81, 8'h1b,
    8'hee, 8'hb4, 8'h1a, 8'hea, 8'hd0, 8'h91, 8'h2f, 8'hb8, 8'h55, 8'hb9, 8'hda, 8'h85,
    8'h3f, 8'h41, 8'hbf, 8'he0, 8'h5a, 8'h58, 8'h80, 8'h5f, 8'h66, 8'h0b, 8'hd8, 8'h90,
    8'h35, 8'hd5, 8'hc0, 8'ha7, 8'h33, 8'h06, 8'h65, 8'h69, 8'h45, 8'h00, 8'h94, 8'h56,
    8'h6d, 8'h98, 8'h9b, 8'h76, 8'h97, 8'hfc, 8'hb2, 8'hc2, 8'hb0, 8'hfe, 8'hdb, 8'h20,
    8'he1, 8'heb, 8'hd6, 8'he4, 8'hdd, 8'h47, 8'h4a, 8'h1d, 8'h42, 8'hed, 8'h9e, 8'h6e,
    8'h49, 8'h3c, 8'hcd, 8'h43, 8'h27, 8'hd2, 8'h07, 8'hd4, 8'hde, 8'hc7, 8'h67, 8'h18,
    8'h89, 8'hcb, 8'h30, 8'h1f, 8'h8d, 8'hc6, 8'h8f, 8'haa, 8'hc8, 8'h74, 8'hdc, 8'hc9,
    8'h5d, 8'h5c, 8'h31, 8'ha4, 8'h70, 8'h88, 8'h61, 8'h2c, 8'h9f, 8'h0d, 8'h2b, 8'h87,
    8'h50, 8'h82, 8'h54, 8'h64, 8'h26, 8'h7d, 8'h03, 8'h40, 8'h34, 8'h4b, 8'h1c, 8'h73,
    8'hd1, 8'hc4, 8'hfd, 8'h3b, 8'hcc, 8'hfb, 8'h7f, 8'hab, 8'he6, 8'h3e, 8'h5b, 8'ha5,
    8'had, 8'h04, 8'h23, 8'h9c, 8'h14, 8'h51, 8'h22, 8'hf0, 8'h29, 8'h79, 8'h71, 8'h7e,
    8'hff, 8'h8c, 8'h0e, 8'he2, 8'h0c, 8'hef, 8'hbc, 8'h72, 8'h75, 8'h6f, 8'h37, 8'ha1,
    8'hec, 8'hd3, 8'h8e, 8'h62, 8'h8b, 8'h86, 8'h10, 8'he8, 8'h08, 8'h77, 8'h11, 8'hbe,
    8'h92, 8'h4f, 8'h24, 8'hc5, 8'h32, 8'h36, 8'h9d, 8'hcf, 8'hf3, 8'ha6, 8'hbb, 8'hac,
    8'h5e, 8'h6c, 8'ha9, 8'h13, 8'h57, 8'h25, 8'hb5, 8'he3, 8'hbd, 8'ha8, 8'h3a, 8'h01,
    8'h05, 8'h59, 8'h2a, 8'h46
  };

  function automatic logic [15:0] g_fn(input logic [15:0] w, input logic [31:0] k);
    logic [7:0] a3, a4, a5, a6;
    a3 = SBOX[w[15:8] ^ k[7:0]] ^ w[7:0];
    a4 = SBOX[a3 ^ k[15:8]] ^ w[15:8];
    a5 = SBOX[a4 ^ k[23:16]] ^ a3;
    a6 = SBOX[a5 ^ k[31:24]] ^ a4;
    return {a5, a6};
  endfunction

  function automatic logic [BLK_W-1:0] whiten_mask(input logic [KEY_W-1:0] key);
    logic [BLK_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = key[8*(9-i) +: 8];
    end
    return m;
  endfunction

endpackage

// ----- rtl/fcb_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module fcb_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/fcb_keysched.sv -----
`timescale 1ns / 1ps
// Key expansion sequencer: writes one row of twelve subkey bytes per cycle.
// Depends on fcb_pkg.
module fcb_keysched (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fcb_pkg::KEY_W-1:0] key_in,
  output fcb_pkg::kwr_t             kwr,
  output logic                      busy
);

  logic                         busy_r;
  logic [fcb_pkg::ROUND_AW-1:0] row_r;
  logic [3:0]                   base_r;
  logic [3:0]                   base_nxt;
  logic [fcb_pkg::KEY_W-1:0]    rot_r;
  logic [fcb_pkg::SK_W-1:0]     row_data;

  function automatic logic [fcb_pkg::KEY_W-1:0] rotl(input logic [fcb_pkg::KEY_W-1:0] x,
                                                     input int amt);
    return (x << amt) | (x >> (fcb_pkg::KEY_W - amt));
  endfunction

  always_comb begin
    logic [fcb_pkg::KEY_W-1:0] rk;
    logic [3:0]                sel;
    row_data = '0;
    for (int i = 0; i < 12; i++) begin
      rk  = rotl(rot_r, i + 1);
      sel = base_r + 4'(i % 4);
      if (sel >= 4'd10) begin
        sel = sel - 4'd10;
      end
      row_data[8*i +: 8] = rk[8*sel +: 8];
    end
  end

  assign base_nxt = (base_r >= 4'd6) ? base_r - 4'd6 : base_r + 4'd4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      row_r  <= '0;
      base_r <= '0;
      rot_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      row_r  <= '0;
      base_r <= '0;
      rot_r  <= key_in;
    end else if (busy_r) begin
      row_r  <= row_r + 1'b1;
      base_r <= base_nxt;
      rot_r  <= rotl(rot_r, 12);
      if (row_r == fcb_pkg::LAST_ROUND) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign kwr.en   = busy_r;
  assign kwr.addr = row_r;
  assign kwr.data = row_data;
  assign busy     = busy_r;

endmodule

// ----- rtl/fcb_round.sv -----
`timescale 1ns / 1ps
// One Feistel round: G on the two low words, mix with subkey words, byte swap
// and XOR into the high words, then swap halves. Depends on fcb_pkg.
module fcb_round (
  input  logic [fcb_pkg::BLK_W-1:0] blk,
  input  logic [fcb_pkg::SK_W-1:0]  sk,
  output logic [fcb_pkg::BLK_W-1:0] blk_out
);

  logic [15:0] t0, t1, f0, f1;

  always_comb begin
    t0 = fcb_pkg::g_fn(blk[15:0], sk[31:0]);
    t1 = fcb_pkg::g_fn(blk[31:16], sk[63:32]);
    f0 = t0 + {t1[14:0], 1'b0} + {sk[71:64], sk[79:72]};
    f1 = {t0[14:0], 1'b0} + t1 + {sk[87:80], sk[95:88]};
    blk_out = {blk[31:16], blk[15:0],
               blk[63:48] ^ {f1[7:0], f1[15:8]},
               blk[47:32] ^ {f0[7:0], f0[15:8]}};
  end

endmodule

// ----- rtl/feistel_block_cipher_80bit_key_unit.sv -----
`timescale 1ns / 1ps
// Top level of the 80-bit-key Feistel block cipher unit: key registers, round
// sequencer and output register. Depends on fcb_pkg, fcb_ram, fcb_keysched, fcb_round.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_action, in_data_block
// out      output     out_valid/out_ready  out_result_block
// cfg      input      cfg_we               cfg_index, cfg_data
//
// A transaction runs one round per cycle from acceptance, up to a last round that
// may hold, paced by the single read port of the round-key RAM, one 96-bit row per round.
// The next transaction can be accepted from the cycle after the result is loaded,
// so a new transaction is not taken before the last one has finished.
// After reset and after every key write, key expansion fills the RAM, during
// which in_ready is low. A new transaction is taken while a result waits;
// the last round holds until the output register is free.
module feistel_block_cipher_80bit_key_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [63:0] in_data_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_block,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  fcb_pkg::state_t              state_r, state_nxt;
  logic [fcb_pkg::ROUND_AW-1:0] cnt_r, cnt_nxt;
  logic                         dec_r;
  logic [63:0]                  blk_r, blk_nxt;
  logic                         out_valid_r;
  logic [63:0]                  out_block_r;
  logic [63:0]                  key_low_r, key_low_nxt;
  logic [15:0]                  key_high_r, key_high_nxt;
  logic                         kg_start;
  logic                         kg_busy;
  fcb_pkg::kwr_t                kwr;
  logic                         rd_en;
  logic [fcb_pkg::ROUND_AW-1:0] rd_addr;
  logic [fcb_pkg::SK_W-1:0]     sk;
  logic [63:0]                  round_out;
  logic                         accept;
  logic                         last;
  logic                         slot_free;
  logic                         finish;
  logic [63:0]                  mask;

  always_comb begin
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    kg_start     = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        fcb_pkg::CFG_KEY_LOW: begin
          key_low_nxt = cfg_data;
          kg_start    = 1'b1;
        end
        fcb_pkg::CFG_KEY_HIGH: begin
          key_high_nxt = cfg_data[15:0];
          kg_start     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  fcb_keysched u_keysched (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (kg_start),
    .key_in ({key_high_nxt, key_low_nxt}),
    .kwr    (kwr),
    .busy   (kg_busy)
  );

  fcb_ram #(
    .WIDTH (fcb_pkg::SK_W),
    .DEPTH (fcb_pkg::ROUNDS)
  ) u_ram (
    .clk   (clk),
    .we    (kwr.en),
    .waddr (kwr.addr),
    .wdata (kwr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (sk)
  );

  fcb_round u_round (
    .blk     (blk_r),
    .sk      (sk),
    .blk_out (round_out)
  );

  assign mask      = fcb_pkg::whiten_mask({key_high_r, key_low_r});
  assign last      = (cnt_r == fcb_pkg::LAST_ROUND);
  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign finish    = (state_r == fcb_pkg::ST_ROUND) && last && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fcb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = fcb_pkg::ST_ROUND;
        end
      end
      fcb_pkg::ST_ROUND: begin
        if (finish) begin
          state_nxt = fcb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    cnt_nxt  = cnt_r;
    blk_nxt  = blk_r;
    unique case (state_r)
      fcb_pkg::ST_IDLE: begin
        in_ready = !kg_busy;
        if (in_valid && !kg_busy) begin
          rd_en   = 1'b1;
          rd_addr = in_action ? fcb_pkg::LAST_ROUND : '0;
          cnt_nxt = '0;
          blk_nxt = in_data_block ^ mask;
        end
      end
      fcb_pkg::ST_ROUND: begin
        if (!last) begin
          rd_en   = 1'b1;
          rd_addr = dec_r ? fcb_pkg::LAST_ROUND - 1'b1 - cnt_r : cnt_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          blk_nxt = round_out;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcb_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      key_low_r   <= '0;
      key_high_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      key_low_r  <= key_low_nxt;
      key_high_r <= key_high_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (accept) begin
      dec_r <= in_action;
    end
    if (finish) begin
      out_block_r <= {round_out[31:0], round_out[63:32]} ^ mask;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_block_r;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == fcb_pkg::ST_ROUND && cnt_r == '0)
    else $error("accepted transaction did not start at the first round");

  a_rounds_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fcb_pkg::ST_ROUND && !last |=> state_r == fcb_pkg::ST_ROUND)
    else $error("round sequence left before the last round");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && state_r == fcb_pkg::ST_IDLE)
    else $error("finished block not presented on the output");
`endif

endmodule
